[src/hpp_pkg.sv]
// Package for the hex polynomial text parser: phase codes, status and kind
// codes, character constants, the result item type and the hex decoder.
// No dependencies.
package hpp_pkg;

  localparam int DEF_MAX_COEFFS = 32768;
  localparam int DEF_COEFF_BITS = 64;
  localparam int Q_DEPTH        = 4;

  typedef enum logic [2:0] {
    PH_COEFF_OR_END = 3'd0,
    PH_COEFF        = 3'd1,
    PH_CARET        = 3'd2,
    PH_POWER        = 3'd3,
    PH_PLUS         = 3'd4,
    PH_SPACE2       = 3'd5
  } phase_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_POWER     = 2'd2;
  localparam logic [1:0] ST_WIDE      = 2'd3;

  localparam logic KIND_TERM    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;

  typedef struct packed {
    logic        kind;
    logic [14:0] term_power;
    logic [63:0] term_value;
    logic [15:0] poly_len;
    logic [1:0]  status;
    logic        last;
  } result_t;

  // bit 4: valid hex digit, bits 3:0: its value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_0 && c <= CH_9) begin
      r = {1'b1, 4'(c - CH_0)};
    end else if (c >= CH_UA && c <= CH_UF) begin
      r = {1'b1, 4'(c - CH_UA + 8'd10)};
    end else if (c >= CH_LA && c <= CH_LF) begin
      r = {1'b1, 4'(c - CH_LA + 8'd10)};
    end
    return r;
  endfunction

endpackage

[src/hex_polynomial_text_parser.sv]
// Top level of the hex polynomial text parser: character decode, term and
// power accumulation, summary generation. Depends on hpp_pkg, hpp_out_fifo.
//
//   channel  dir  fields
//   s_*      in   tdata: text_char; tlast: end_mark
//   m_*      out  tdata: term_power, term_value, poly_len, status;
//                 tuser: kind; tlast: last
//
// One character per cycle while s_tready is high; each item is decoded in the cycle it is accepted.
// An end marker that closes a term whose coefficient fits yields two items,
// queued in a 4-entry result queue; s_tready drops only when fewer than two
// entries are free. Synchronous reset clears the parser state and empties the
// queue. Output stalls back up through the queue only.
module hex_polynomial_text_parser #(
  parameter int MAX_COEFFS = hpp_pkg::DEF_MAX_COEFFS,
  parameter int COEFF_BITS = hpp_pkg::DEF_COEFF_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // text_char[7:0]
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // term_power[14:0], term_value[78:15],
                                  // poly_len[94:79], status[96:95], zero pad
  output logic         m_tuser,   // kind
  output logic         m_tlast
);
  import hpp_pkg::*;

  localparam int PW = $clog2(MAX_COEFFS + 1);
  localparam logic [PW+3:0] MAX_V  = (PW + 4)'(MAX_COEFFS);
  localparam logic [PW-1:0] MAX_PW = PW'(MAX_COEFFS);

  phase_t                phase, phase_next;
  logic [COEFF_BITS-1:0] coeff_accum, coeff_accum_next;
  logic                  coeff_too_wide, coeff_too_wide_next;
  logic [PW-1:0]         power_accum, power_accum_next;
  logic                  power_saturated, power_saturated_next;
  logic [PW-1:0]         previous_power, previous_power_next;
  logic [PW-1:0]         first_count, first_count_next;
  logic                  seen_nonzero, seen_nonzero_next;
  logic [1:0]            error_code, error_code_next;

  logic       acc;
  logic       end_mark;
  logic [7:0] c;
  logic [4:0] hex;
  logic       is_dec;
  logic [3:0] dec_val;
  logic [PW+3:0] pw_mul;
  logic       do_close;
  logic [PW-1:0] close_pw;
  logic       close_sat;
  logic       close_bad;
  logic       close_ok;
  logic       term_emit;
  logic       seen_after;
  logic [PW-1:0] first_after;
  logic [1:0] end_err;
  logic [1:0] sum_status;
  result_t    term_res, sum_res, entry0;
  logic [1:0] push_n;
  logic       fifo_room;
  logic       fifo_ne;
  result_t    head;

  assign acc      = s_tvalid && s_tready;
  assign end_mark = s_tlast;
  assign c        = s_tdata;
  assign hex      = hex_decode(c);
  assign is_dec   = c >= CH_0 && c <= CH_9;
  assign dec_val  = 4'(c - CH_0);
  assign pw_mul   = ({4'd0, power_accum} << 3) + ({4'd0, power_accum} << 1)
                    + (PW + 4)'(dec_val);

  // term close decision
  always_comb begin
    close_pw  = power_accum;
    close_sat = power_saturated;
    do_close  = 1'b0;
    if (error_code == ST_OK) begin
      if (end_mark) begin
        if (phase == PH_COEFF) begin
          do_close  = 1'b1;
          close_pw  = '0;
          close_sat = 1'b0;
        end else if (phase == PH_POWER) begin
          do_close = 1'b1;
        end
      end else if (phase == PH_POWER && c == CH_SPACE) begin
        do_close = 1'b1;
      end
    end
    close_bad   = close_sat || close_pw >= previous_power;
    close_ok    = do_close && !close_bad;
    term_emit   = close_ok && !coeff_too_wide;
    seen_after  = seen_nonzero || (close_ok && coeff_accum != '0);
    first_after = (close_ok && first_count == '0) ? close_pw + PW'(1) : first_count;
    if (error_code != ST_OK) begin
      end_err = error_code;
    end else if (do_close && close_bad) begin
      end_err = ST_POWER;
    end else if (phase != PH_COEFF_OR_END && phase != PH_COEFF && phase != PH_POWER) begin
      end_err = ST_MALFORMED;
    end else begin
      end_err = ST_OK;
    end
    sum_status = (end_err != ST_OK) ? end_err : (coeff_too_wide ? ST_WIDE : ST_OK);
  end

  // next state
  always_comb begin
    phase_next           = phase;
    coeff_accum_next     = coeff_accum;
    coeff_too_wide_next  = coeff_too_wide;
    power_accum_next     = power_accum;
    power_saturated_next = power_saturated;
    previous_power_next  = previous_power;
    first_count_next     = first_count;
    seen_nonzero_next    = seen_nonzero;
    error_code_next      = error_code;
    if (end_mark) begin
      phase_next           = PH_COEFF_OR_END;
      coeff_accum_next     = '0;
      coeff_too_wide_next  = 1'b0;
      power_accum_next     = '0;
      power_saturated_next = 1'b0;
      previous_power_next  = MAX_PW;
      first_count_next     = '0;
      seen_nonzero_next    = 1'b0;
      error_code_next      = ST_OK;
    end else if (error_code == ST_OK) begin
      unique case (phase) inside
        PH_COEFF_OR_END, PH_COEFF: begin
          if (hex[4]) begin
            if (coeff_accum[COEFF_BITS-1 -: 4] != 4'd0) begin
              coeff_too_wide_next = 1'b1;
            end
            coeff_accum_next = {coeff_accum[COEFF_BITS-5:0], hex[3:0]};
            phase_next       = PH_COEFF;
          end else if (phase == PH_COEFF && c == CH_X) begin
            phase_next = PH_CARET;
          end else begin
            error_code_next = ST_MALFORMED;
          end
        end
        PH_CARET: begin
          if (c == CH_CARET) begin
            power_accum_next     = '0;
            power_saturated_next = 1'b0;
            phase_next           = PH_POWER;
          end else begin
            error_code_next = ST_MALFORMED;
          end
        end
        PH_POWER: begin
          if (is_dec) begin
            if (pw_mul > MAX_V) begin
              power_accum_next     = MAX_PW;
              power_saturated_next = 1'b1;
            end else begin
              power_accum_next = pw_mul[PW-1:0];
            end
          end else if (c == CH_SPACE) begin
            if (close_bad) begin
              error_code_next = ST_POWER;
            end else begin
              previous_power_next  = close_pw;
              first_count_next     = first_after;
              seen_nonzero_next    = seen_after;
              coeff_accum_next     = '0;
              power_accum_next     = '0;
              power_saturated_next = 1'b0;
              phase_next           = PH_PLUS;
            end
          end else begin
            error_code_next = ST_MALFORMED;
          end
        end
        PH_PLUS: begin
          if (c == CH_PLUS) begin
            phase_next = PH_SPACE2;
          end else begin
            error_code_next = ST_MALFORMED;
          end
        end
        PH_SPACE2: begin
          if (c == CH_SPACE) begin
            phase_next = PH_COEFF_OR_END;
          end else begin
            error_code_next = ST_MALFORMED;
          end
        end
        default: begin
          error_code_next = ST_MALFORMED;
        end
      endcase
    end
  end

  // result items
  always_comb begin
    term_res.kind        = KIND_TERM;
    term_res.term_power  = 15'(close_pw);
    term_res.term_value  = 64'(coeff_accum);
    term_res.poly_len    = 16'd0;
    term_res.status      = ST_OK;
    term_res.last        = !end_mark;
    sum_res.kind         = KIND_SUMMARY;
    sum_res.term_power   = 15'd0;
    sum_res.term_value   = 64'd0;
    sum_res.poly_len     = (sum_status == ST_OK && seen_after) ? 16'(first_after) : 16'd0;
    sum_res.status       = sum_status;
    sum_res.last         = 1'b1;
    entry0               = term_emit ? term_res : sum_res;
    push_n               = acc ? (2'(term_emit) + 2'(end_mark)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_COEFF_OR_END;
      coeff_accum     <= '0;
      coeff_too_wide  <= 1'b0;
      power_accum     <= '0;
      power_saturated <= 1'b0;
      previous_power  <= MAX_PW;
      first_count     <= '0;
      seen_nonzero    <= 1'b0;
      error_code      <= ST_OK;
    end else if (acc) begin
      phase           <= phase_next;
      coeff_accum     <= coeff_accum_next;
      coeff_too_wide  <= coeff_too_wide_next;
      power_accum     <= power_accum_next;
      power_saturated <= power_saturated_next;
      previous_power  <= previous_power_next;
      first_count     <= first_count_next;
      seen_nonzero    <= seen_nonzero_next;
      error_code      <= error_code_next;
    end
  end

  hpp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .entry0    (entry0),
    .entry1    (sum_res),
    .pop       (m_tvalid && m_tready),
    .room      (fifo_room),
    .not_empty (fifo_ne),
    .head      (head)
  );

  assign s_tready = fifo_room;
  assign m_tvalid = fifo_ne;
  assign m_tdata  = {7'd0, head.status, head.poly_len, head.term_value, head.term_power};
  assign m_tuser  = head.kind;
  assign m_tlast  = head.last;

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    acc && s_tlast |=> phase == PH_COEFF_OR_END && error_code == ST_OK
                       && previous_power == MAX_PW && first_count == '0)
    else $error("parser state not cleared after end marker");

  a_no_term_after_error: assert property (@(posedge clk) disable iff (rst)
    acc && !s_tlast && error_code != ST_OK |-> push_n == 2'd0)
    else $error("item produced after an error");

  a_pair_only_at_end: assert property (@(posedge clk) disable iff (rst)
    push_n == 2'd2 |-> acc && s_tlast && term_emit)
    else $error("two results without end marker");

  a_prev_power_range: assert property (@(posedge clk) disable iff (rst)
    previous_power <= MAX_PW)
    else $error("previous power above limit");

endmodule

[src/hpp_out_fifo.sv]
// Result queue of the hex polynomial text parser: takes up to two items per
// cycle and hands them out one at a time. Depends on hpp_pkg.
module hpp_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_n,
  input  hpp_pkg::result_t  entry0,
  input  hpp_pkg::result_t  entry1,
  input  logic              pop,
  output logic              room,
  output logic              not_empty,
  output hpp_pkg::result_t  head
);
  import hpp_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  result_t            mem [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign room      = count <= CNT_W'(Q_DEPTH - 2);
  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= entry0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= entry1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

endmodule
